>>> sv/awt_pkg.sv
// Package: shared types and constants for the adaptive waypoint tracker.
`timescale 1ns / 1ps
package awt_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned CURV_W     = 16;
  localparam int unsigned SPC_W      = 16;
  localparam int unsigned FS_W       = 15;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned SQ_W       = 49;
  localparam int unsigned D2_W       = 50;
  localparam int unsigned ROOT_W     = 25;
  localparam int unsigned REM_W      = 28;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DREM_W     = 16;
  localparam int unsigned RR_W       = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURV_FS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REACH       = 2'd3;

  localparam logic [SPC_W-1:0] MIN_SPACING_RST = 16'd100;
  localparam logic [SPC_W-1:0] MAX_SPACING_RST = 16'd500;
  localparam logic [FS_W-1:0]  CURV_FS_RST     = 15'd1229;
  localparam logic [SPC_W-1:0] REACH_RST       = 16'd1400;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_FIRST,
    OP_MUL_PREV,
    OP_MUL_MEM,
    OP_SUM,
    OP_SUM_SQ,
    OP_SQRT,
    OP_ACC,
    OP_SP_MUL,
    OP_SP_SUM,
    OP_DIV,
    OP_DECIDE,
    OP_COMMIT,
    OP_SCAN_CMP,
    OP_SCAN_FIN,
    OP_FIX_CUR,
    OP_REACH,
    OP_TRK_OUT,
    OP_EMPTY_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIRST,
    S_P_MUL,
    S_P_SUM,
    S_SQRT,
    S_ACC,
    S_SP_MUL,
    S_SP_SUM,
    S_DIV,
    S_DECIDE,
    S_KEEP,
    S_SC_RD,
    S_SC_MUL,
    S_SC_SUM,
    S_SC_CMP,
    S_SC_FIN,
    S_T_FIX,
    S_T_RD,
    S_T_MUL,
    S_T_SUM,
    S_T_REACH,
    S_T_RD2,
    S_T_OUT,
    S_EMPTY
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   rd_cur;
  } awt_cmd_t;

  typedef struct packed {
    logic cmd_trk;
    logic first_seen;
    logic search_done;
    logic empty;
    logic scan_last;
  } awt_sts_t;

endpackage

>>> sv/awt_ctrl.sv
// Controller: sequences the datapath for path points and position samples.
`timescale 1ns / 1ps
module awt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  awt_pkg::awt_sts_t   sts_i,
  output awt_pkg::awt_cmd_t   cmd_o
);

  awt_pkg::ctl_state_e state_q, state_d;
  logic [awt_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign busy = (state_q != awt_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= awt_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      awt_pkg::S_IDLE:     if (start) state_d = awt_pkg::S_DISPATCH;
      awt_pkg::S_DISPATCH: begin
        if (!sts_i.cmd_trk) begin
          state_d = sts_i.first_seen ? awt_pkg::S_P_MUL : awt_pkg::S_FIRST;
        end else if (sts_i.empty) begin
          state_d = awt_pkg::S_EMPTY;
        end else begin
          state_d = sts_i.search_done ? awt_pkg::S_T_FIX : awt_pkg::S_SC_RD;
        end
      end
      awt_pkg::S_FIRST:    state_d = awt_pkg::S_KEEP;
      awt_pkg::S_P_MUL:    state_d = awt_pkg::S_P_SUM;
      awt_pkg::S_P_SUM:    state_d = awt_pkg::S_SQRT;
      awt_pkg::S_SQRT:     if (cnt_q == '0) state_d = awt_pkg::S_ACC;
      awt_pkg::S_ACC:      state_d = awt_pkg::S_SP_MUL;
      awt_pkg::S_SP_MUL:   state_d = awt_pkg::S_SP_SUM;
      awt_pkg::S_SP_SUM:   state_d = awt_pkg::S_DIV;
      awt_pkg::S_DIV:      if (cnt_q == '0) state_d = awt_pkg::S_DECIDE;
      awt_pkg::S_DECIDE:   state_d = awt_pkg::S_KEEP;
      awt_pkg::S_KEEP:     state_d = awt_pkg::S_IDLE;
      awt_pkg::S_SC_RD:    state_d = awt_pkg::S_SC_MUL;
      awt_pkg::S_SC_MUL:   state_d = awt_pkg::S_SC_SUM;
      awt_pkg::S_SC_SUM:   state_d = awt_pkg::S_SC_CMP;
      awt_pkg::S_SC_CMP:   state_d = sts_i.scan_last ? awt_pkg::S_SC_FIN : awt_pkg::S_SC_RD;
      awt_pkg::S_SC_FIN:   state_d = awt_pkg::S_T_FIX;
      awt_pkg::S_T_FIX:    state_d = awt_pkg::S_T_RD;
      awt_pkg::S_T_RD:     state_d = awt_pkg::S_T_MUL;
      awt_pkg::S_T_MUL:    state_d = awt_pkg::S_T_SUM;
      awt_pkg::S_T_SUM:    state_d = awt_pkg::S_T_REACH;
      awt_pkg::S_T_REACH:  state_d = awt_pkg::S_T_RD2;
      awt_pkg::S_T_RD2:    state_d = awt_pkg::S_T_OUT;
      awt_pkg::S_T_OUT:    state_d = awt_pkg::S_IDLE;
      awt_pkg::S_EMPTY:    state_d = awt_pkg::S_IDLE;
      default:             state_d = awt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == awt_pkg::S_P_SUM) begin
      cnt_d = awt_pkg::CNT_W'(awt_pkg::SQRT_STEPS - 1);
    end else if (state_q == awt_pkg::S_SP_SUM) begin
      cnt_d = awt_pkg::CNT_W'(awt_pkg::DIV_STEPS - 1);
    end else if ((state_q == awt_pkg::S_SQRT || state_q == awt_pkg::S_DIV) && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    cmd_o.op     = awt_pkg::OP_NOP;
    cmd_o.rd_cur = 1'b1;
    unique case (state_q)
      awt_pkg::S_IDLE:    if (start) cmd_o.op = awt_pkg::OP_LOAD;
      awt_pkg::S_FIRST:   cmd_o.op = awt_pkg::OP_FIRST;
      awt_pkg::S_P_MUL:   cmd_o.op = awt_pkg::OP_MUL_PREV;
      awt_pkg::S_P_SUM:   cmd_o.op = awt_pkg::OP_SUM_SQ;
      awt_pkg::S_SQRT:    cmd_o.op = awt_pkg::OP_SQRT;
      awt_pkg::S_ACC:     cmd_o.op = awt_pkg::OP_ACC;
      awt_pkg::S_SP_MUL:  cmd_o.op = awt_pkg::OP_SP_MUL;
      awt_pkg::S_SP_SUM:  cmd_o.op = awt_pkg::OP_SP_SUM;
      awt_pkg::S_DIV:     cmd_o.op = awt_pkg::OP_DIV;
      awt_pkg::S_DECIDE:  cmd_o.op = awt_pkg::OP_DECIDE;
      awt_pkg::S_KEEP:    cmd_o.op = awt_pkg::OP_COMMIT;
      awt_pkg::S_SC_RD:   cmd_o.rd_cur = 1'b0;
      awt_pkg::S_SC_MUL:  begin
        cmd_o.op     = awt_pkg::OP_MUL_MEM;
        cmd_o.rd_cur = 1'b0;
      end
      awt_pkg::S_SC_SUM:  begin
        cmd_o.op     = awt_pkg::OP_SUM;
        cmd_o.rd_cur = 1'b0;
      end
      awt_pkg::S_SC_CMP:  begin
        cmd_o.op     = awt_pkg::OP_SCAN_CMP;
        cmd_o.rd_cur = 1'b0;
      end
      awt_pkg::S_SC_FIN:  cmd_o.op = awt_pkg::OP_SCAN_FIN;
      awt_pkg::S_T_FIX:   cmd_o.op = awt_pkg::OP_FIX_CUR;
      awt_pkg::S_T_MUL:   cmd_o.op = awt_pkg::OP_MUL_MEM;
      awt_pkg::S_T_SUM:   cmd_o.op = awt_pkg::OP_SUM;
      awt_pkg::S_T_REACH: cmd_o.op = awt_pkg::OP_REACH;
      awt_pkg::S_T_OUT:   cmd_o.op = awt_pkg::OP_TRK_OUT;
      awt_pkg::S_EMPTY:   cmd_o.op = awt_pkg::OP_EMPTY_OUT;
      default:            cmd_o.op = awt_pkg::OP_NOP;
    endcase
  end

endmodule

>>> sv/awt_dp.sv
// Datapath: waypoint memory, distance, square root, spacing divider, search and results.
`timescale 1ns / 1ps
module awt_dp #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  awt_pkg::awt_cmd_t                   cmd_i,
  output awt_pkg::awt_sts_t                   sts_o,
  input  logic                                command_i,
  input  logic signed [awt_pkg::COORD_W-1:0]  x_mm_i,
  input  logic signed [awt_pkg::COORD_W-1:0]  y_mm_i,
  input  logic signed [awt_pkg::CURV_W-1:0]   curvature_i,
  input  logic                                cfg_we_i,
  input  logic [awt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [awt_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic                                point_kept_o,
  output logic                                table_full_o,
  output logic [CntW-1:0]                     waypoint_count_o,
  output logic                                target_valid_o,
  output logic                                reached_o,
  output logic [IdxW-1:0]                     target_index_o,
  output logic signed [awt_pkg::COORD_W-1:0]  target_x_mm_o,
  output logic signed [awt_pkg::COORD_W-1:0]  target_y_mm_o
);

  localparam int unsigned CW = awt_pkg::COORD_W;

  // configuration
  logic [awt_pkg::SPC_W-1:0] min_sp_q, max_sp_q, reach_q;
  logic [awt_pkg::FS_W-1:0]  fs_q;

  // transaction and state
  logic                          cmd_q;
  logic signed [CW-1:0]          x_q, y_q, prev_x_q, prev_y_q;
  logic signed [awt_pkg::CURV_W-1:0] curv_q;
  logic [awt_pkg::ACC_W-1:0]     acc_q;
  logic                          first_q, search_q, keep_q, reached_q;
  logic [CntW-1:0]               count_q;
  logic [IdxW-1:0]               cur_q, scan_q, best_i_q;
  logic [awt_pkg::D2_W-1:0]      best_q;

  // memory
  logic [2*CW-1:0]               mem [TABLE_DEPTH];
  logic [2*CW-1:0]               rd_q;
  logic [IdxW-1:0]               rd_addr;
  logic                          wr_en;
  logic signed [CW-1:0]          rd_x, rd_y;

  // arithmetic
  logic signed [CW-1:0]          ox, oy;
  logic signed [CW:0]            dx, dy;
  logic signed [2*CW+1:0]        px, py;
  logic [awt_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [awt_pkg::RR_W-1:0]      rr_q;
  logic [awt_pkg::D2_W-1:0]      d2_q, d2_sum;
  logic [awt_pkg::D2_W-1:0]      rad_q;
  logic [awt_pkg::REM_W-1:0]     rem_q, rem2, trial;
  logic [awt_pkg::ROOT_W-1:0]    root_q;
  logic [awt_pkg::ACC_W:0]       acc_sum;
  logic [awt_pkg::CURV_W-1:0]    mag;
  logic [awt_pkg::FS_W-1:0]      n_val;
  logic [2*awt_pkg::FS_W:0]      p1_q, p2_q;
  logic [awt_pkg::NUM_W-1:0]     numq_q;
  logic [awt_pkg::DREM_W-1:0]    drem_q, drem2;
  logic                          full;
  logic [CntW-1:0]               cur_inc;

  assign rd_x = rd_q[2*CW-1:CW];
  assign rd_y = rd_q[CW-1:0];
  assign full = (count_q == CntW'(TABLE_DEPTH));
  assign cur_inc = CntW'(cur_q) + 1'b1;

  assign sts_o.cmd_trk     = cmd_q;
  assign sts_o.first_seen  = first_q;
  assign sts_o.search_done = search_q;
  assign sts_o.empty       = (count_q == '0);
  assign sts_o.scan_last   = ((CntW'(scan_q) + 1'b1) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sp_q <= awt_pkg::MIN_SPACING_RST;
      max_sp_q <= awt_pkg::MAX_SPACING_RST;
      fs_q     <= awt_pkg::CURV_FS_RST;
      reach_q  <= awt_pkg::REACH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        awt_pkg::REG_MIN_SPACING: min_sp_q <= cfg_wdata_i;
        awt_pkg::REG_MAX_SPACING: max_sp_q <= cfg_wdata_i;
        awt_pkg::REG_CURV_FS:     fs_q     <= cfg_wdata_i[awt_pkg::FS_W-1:0];
        awt_pkg::REG_REACH:       reach_q  <= cfg_wdata_i;
        default:                  ;
      endcase
    end
  end

  // waypoint memory, one write and one registered read per cycle
  assign rd_addr = cmd_i.rd_cur ? cur_q : scan_q;
  assign wr_en   = (cmd_i.op == awt_pkg::OP_COMMIT) && keep_q && !full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= {x_q, y_q};
    end
    rd_q <= mem[rd_addr];
  end

  // distance squares
  assign ox = (cmd_i.op == awt_pkg::OP_MUL_PREV) ? prev_x_q : rd_x;
  assign oy = (cmd_i.op == awt_pkg::OP_MUL_PREV) ? prev_y_q : rd_y;
  assign dx = {x_q[CW-1], x_q} - {ox[CW-1], ox};
  assign dy = {y_q[CW-1], y_q} - {oy[CW-1], oy};
  assign px = dx * dx;
  assign py = dy * dy;
  assign d2_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  // square root step, two radicand bits per cycle
  assign rem2  = {rem_q[awt_pkg::REM_W-3:0], rad_q[awt_pkg::D2_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  // spacing divider step, one quotient bit per cycle
  assign drem2 = {drem_q[awt_pkg::DREM_W-2:0], numq_q[awt_pkg::NUM_W-1]};

  assign acc_sum = {1'b0, acc_q} + {1'b0, root_q};
  assign mag     = curv_q[awt_pkg::CURV_W-1] ? awt_pkg::CURV_W'(-curv_q)
                                             : awt_pkg::CURV_W'(curv_q);
  assign n_val   = (mag > {1'b0, fs_q}) ? fs_q : mag[awt_pkg::FS_W-1:0];

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      awt_pkg::OP_LOAD: begin
        cmd_q  <= command_i;
        x_q    <= x_mm_i;
        y_q    <= y_mm_i;
        curv_q <= curvature_i;
      end
      awt_pkg::OP_FIRST: keep_q <= 1'b1;
      awt_pkg::OP_MUL_PREV, awt_pkg::OP_MUL_MEM: begin
        sqx_q <= px[awt_pkg::SQ_W-1:0];
        sqy_q <= py[awt_pkg::SQ_W-1:0];
        rr_q  <= reach_q * reach_q;
      end
      awt_pkg::OP_SUM: d2_q <= d2_sum;
      awt_pkg::OP_SUM_SQ: begin
        rad_q  <= d2_sum;
        rem_q  <= '0;
        root_q <= '0;
      end
      awt_pkg::OP_SQRT: begin
        rad_q <= {rad_q[awt_pkg::D2_W-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem_q  <= rem2 - trial;
          root_q <= {root_q[awt_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem2;
          root_q <= {root_q[awt_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      awt_pkg::OP_SP_MUL: begin
        p1_q <= (2*awt_pkg::FS_W+1)'(max_sp_q * (fs_q - n_val));
        p2_q <= (2*awt_pkg::FS_W+1)'(min_sp_q * n_val);
      end
      awt_pkg::OP_SP_SUM: begin
        numq_q <= {1'b0, p1_q} + {1'b0, p2_q};
        drem_q <= '0;
      end
      awt_pkg::OP_DIV: begin
        if (drem2 >= {1'b0, fs_q}) begin
          drem_q <= drem2 - {1'b0, fs_q};
          numq_q <= {numq_q[awt_pkg::NUM_W-2:0], 1'b1};
        end else begin
          drem_q <= drem2;
          numq_q <= {numq_q[awt_pkg::NUM_W-2:0], 1'b0};
        end
      end
      awt_pkg::OP_DECIDE: begin
        if (fs_q == '0) keep_q <= ({9'd0, min_sp_q} <= acc_q);
        else            keep_q <= (numq_q <= {7'd0, acc_q});
      end
      awt_pkg::OP_SCAN_CMP: begin
        if (scan_q == '0 || d2_q < best_q) begin
          best_q   <= d2_q;
          best_i_q <= scan_q;
        end
      end
      awt_pkg::OP_REACH: reached_q <= (d2_q < {18'd0, rr_q});
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b0;
      search_q <= 1'b0;
      count_q  <= '0;
      cur_q    <= '0;
      scan_q   <= '0;
      acc_q    <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      done_o   <= 1'b0;
    end else begin
      done_o <= (cmd_i.op == awt_pkg::OP_COMMIT) || (cmd_i.op == awt_pkg::OP_TRK_OUT) ||
                (cmd_i.op == awt_pkg::OP_EMPTY_OUT);
      unique case (cmd_i.op)
        awt_pkg::OP_LOAD:     scan_q <= '0;
        awt_pkg::OP_FIRST:    first_q <= 1'b1;
        awt_pkg::OP_ACC:      acc_q <= acc_sum[awt_pkg::ACC_W] ? '1 : acc_sum[awt_pkg::ACC_W-1:0];
        awt_pkg::OP_COMMIT: begin
          if (keep_q) begin
            acc_q <= '0;
            if (!full) count_q <= count_q + 1'b1;
          end
          prev_x_q <= x_q;
          prev_y_q <= y_q;
        end
        awt_pkg::OP_SCAN_CMP: scan_q <= scan_q + 1'b1;
        awt_pkg::OP_SCAN_FIN: begin
          cur_q    <= best_i_q;
          search_q <= 1'b1;
        end
        awt_pkg::OP_FIX_CUR:  if (CntW'(cur_q) >= count_q) cur_q <= '0;
        awt_pkg::OP_REACH: begin
          if (d2_q < {18'd0, rr_q}) begin
            cur_q <= (cur_inc == count_q) ? '0 : cur_inc[IdxW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      awt_pkg::OP_COMMIT: begin
        point_kept_o     <= keep_q && !full;
        table_full_o     <= keep_q && full;
        waypoint_count_o <= (keep_q && !full) ? count_q + 1'b1 : count_q;
        target_valid_o   <= 1'b0;
        reached_o        <= 1'b0;
        target_index_o   <= '0;
        target_x_mm_o    <= '0;
        target_y_mm_o    <= '0;
      end
      awt_pkg::OP_TRK_OUT: begin
        point_kept_o     <= 1'b0;
        table_full_o     <= 1'b0;
        waypoint_count_o <= count_q;
        target_valid_o   <= 1'b1;
        reached_o        <= reached_q;
        target_index_o   <= cur_q;
        target_x_mm_o    <= rd_x;
        target_y_mm_o    <= rd_y;
      end
      awt_pkg::OP_EMPTY_OUT: begin
        point_kept_o     <= 1'b0;
        table_full_o     <= 1'b0;
        waypoint_count_o <= count_q;
        target_valid_o   <= 1'b0;
        reached_o        <= 1'b0;
        target_index_o   <= '0;
        target_x_mm_o    <= '0;
        target_y_mm_o    <= '0;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/adaptive_waypoint_tracker_unit.sv
// Top level: adaptive waypoint tracker, controller plus datapath.
`timescale 1ns / 1ps
// One transaction at a time: start is taken while busy is low, and the result
// appears on the result ports for one cycle with done_o high, which the receiver
// cannot stall. A path point runs through the 25-step square root and the
// 32-step spacing divider (the first point skips both). A position sample
// after the first runs no search; the first sample searches every stored
// waypoint for the nearest through the single memory read port. An empty
// table is answered without a search. No clearing pass.
module adaptive_waypoint_tracker_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command_i,
  input  logic signed [awt_pkg::COORD_W-1:0]  x_mm_i,
  input  logic signed [awt_pkg::COORD_W-1:0]  y_mm_i,
  input  logic signed [awt_pkg::CURV_W-1:0]   curvature_i,
  input  logic                                cfg_we_i,
  input  logic [awt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [awt_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic                                point_kept_o,
  output logic                                table_full_o,
  output logic [CntW-1:0]                     waypoint_count_o,
  output logic                                target_valid_o,
  output logic                                reached_o,
  output logic [IdxW-1:0]                     target_index_o,
  output logic signed [awt_pkg::COORD_W-1:0]  target_x_mm_o,
  output logic signed [awt_pkg::COORD_W-1:0]  target_y_mm_o
);

  awt_pkg::awt_cmd_t cmd;
  awt_pkg::awt_sts_t sts;

  awt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  awt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (command_i),
    .x_mm_i           (x_mm_i),
    .y_mm_i           (y_mm_i),
    .curvature_i      (curvature_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .point_kept_o     (point_kept_o),
    .table_full_o     (table_full_o),
    .waypoint_count_o (waypoint_count_o),
    .target_valid_o   (target_valid_o),
    .reached_o        (reached_o),
    .target_index_o   (target_index_o),
    .target_x_mm_o    (target_x_mm_o),
    .target_y_mm_o    (target_y_mm_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && target_valid_o) |-> (CntW'(target_index_o) < waypoint_count_o))
    else $error("target index beyond waypoint count");

  a_kept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(point_kept_o && table_full_o))
    else $error("point both kept and dropped");

endmodule

>>> dv/adaptive_waypoint_tracker_unit_tb.sv
// Testbench: directed table plus random phases, checked against a behavioral tracker model.
`timescale 1ns / 1ps
module adaptive_waypoint_tracker_unit_tb;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned WD_LIMIT = 40000;
  localparam logic        CMD_PATH  = 1'b0;
  localparam logic        CMD_TRACK = 1'b1;

  typedef struct {
    logic        kept;
    logic        full;
    logic [10:0] count;
    logic        valid;
    logic        reached;
    logic [9:0]  idx;
    logic [23:0] tx;
    logic [23:0] ty;
  } tracker_result_t;

  typedef struct {
    logic                   cmd;
    logic signed [23:0]     x;
    logic signed [23:0]     y;
    logic signed [15:0]     curv;
    bit                     typed;
    tracker_result_t        res;
  } tracker_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic command_i = 1'b0;
  logic signed [23:0] x_mm_i = '0;
  logic signed [23:0] y_mm_i = '0;
  logic signed [15:0] curvature_i = '0;
  logic cfg_we_i = 1'b0;
  logic [awt_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [awt_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic done_o, point_kept_o, table_full_o, target_valid_o, reached_o;
  logic [10:0] waypoint_count_o;
  logic [9:0] target_index_o;
  logic signed [23:0] target_x_mm_o, target_y_mm_o;

  adaptive_waypoint_tracker_unit #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [23:0] wp_x [DEPTH];
  logic signed [23:0] wp_y [DEPTH];
  int unsigned n_stored;
  longint prev_x, prev_y;
  longint unsigned dist_acc;
  bit first_seen, nearest_found;
  int unsigned cur_idx;
  longint unsigned min_sp, max_sp, curv_fs, reach_r;

  tracker_result_t expected_q[$];
  tracker_item_t   directed[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 0;
  longint walk_x = 0, walk_y = 0;

  function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned spacing(logic signed [15:0] curv);
    longint unsigned n;
    n = (curv < 0) ? longint'(-longint'(curv)) : longint'(curv);
    if (curv_fs == 0) return min_sp;
    if (n > curv_fs) n = curv_fs;
    return (max_sp * (curv_fs - n) + min_sp * n) / curv_fs;
  endfunction

  function automatic tracker_result_t track_step(tracker_item_t it);
    tracker_result_t r;
    bit keep;
    longint unsigned best, d;
    int unsigned best_i;
    r = '{default: '0};
    if (it.cmd == CMD_PATH) begin
      if (!first_seen) begin
        keep = 1;
        first_seen = 1;
      end else begin
        dist_acc += floor_sqrt(sq_dist(it.x, it.y, prev_x, prev_y));
        if (dist_acc > 64'h1FF_FFFF) dist_acc = 64'h1FF_FFFF;
        keep = dist_acc >= spacing(it.curv);
      end
      if (keep) begin
        dist_acc = 0;
        if (n_stored < DEPTH) begin
          wp_x[n_stored] = it.x;
          wp_y[n_stored] = it.y;
          n_stored++;
          r.kept = 1;
        end else begin
          r.full = 1;
        end
      end
      prev_x = it.x;
      prev_y = it.y;
    end else if (n_stored != 0) begin
      if (!nearest_found) begin
        best = 0;
        best_i = 0;
        for (int unsigned i = 0; i < n_stored; i++) begin
          d = sq_dist(it.x, it.y, wp_x[i], wp_y[i]);
          if (i == 0 || d < best) begin
            best = d;
            best_i = i;
          end
        end
        cur_idx = best_i;
        nearest_found = 1;
      end
      if (cur_idx >= n_stored) cur_idx = 0;
      if (sq_dist(it.x, it.y, wp_x[cur_idx], wp_y[cur_idx]) < reach_r * reach_r) begin
        r.reached = 1;
        cur_idx = (cur_idx + 1) % n_stored;
      end
      r.valid = 1;
      r.idx = cur_idx[9:0];
      r.tx = wp_x[cur_idx];
      r.ty = wp_y[cur_idx];
    end
    r.count = n_stored[10:0];
    return r;
  endfunction

  task automatic idle_gap();
    int unsigned n;
    if (no_gaps) n = 0;
    else if ($urandom_range(0, 9) < 8) n = $urandom_range(0, 2);
    else n = $urandom_range(10, 60);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic send(tracker_item_t it);
    tracker_result_t r;
    idle_gap();
    @(negedge clk_i);
    start = 1'b1;
    command_i = it.cmd;
    x_mm_i = it.x;
    y_mm_i = it.y;
    curvature_i = it.curv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = track_step(it);
    if (it.typed) r = it.res;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [awt_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val[15:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      awt_pkg::REG_MIN_SPACING: min_sp = val & 16'hFFFF;
      awt_pkg::REG_MAX_SPACING: max_sp = val & 16'hFFFF;
      awt_pkg::REG_CURV_FS:     curv_fs = val & 15'h7FFF;
      default:                  reach_r = val & 16'hFFFF;
    endcase
  endtask

  task automatic set_all(longint unsigned mn, longint unsigned mx, longint unsigned fs,
                         longint unsigned rr);
    write_cfg(awt_pkg::REG_MIN_SPACING, mn);
    write_cfg(awt_pkg::REG_MAX_SPACING, mx);
    write_cfg(awt_pkg::REG_CURV_FS, fs);
    write_cfg(awt_pkg::REG_REACH, rr);
  endtask

  task automatic add_row(logic cmd, logic signed [23:0] x, logic signed [23:0] y,
                         logic signed [15:0] c, bit typed, tracker_result_t r);
    tracker_item_t it;
    it.cmd = cmd;
    it.x = x;
    it.y = y;
    it.curv = c;
    it.typed = typed;
    it.res = r;
    directed.insert(directed.size(), it);
  endtask

  function automatic tracker_item_t rand_item(int unsigned track_pct, int unsigned step);
    tracker_item_t it;
    int unsigned k;
    it.typed = 0;
    it.res = '{default: '0};
    it.cmd = ($urandom_range(0, 99) < track_pct);
    it.curv = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
              $signed(16'($urandom_range(0, 2400))) - 16'sd1200;
    if ($urandom_range(0, 19) == 0) begin
      it.x = 24'($urandom());
      it.y = 24'($urandom());
    end else if (it.cmd && n_stored != 0) begin
      k = $urandom_range(0, n_stored - 1);
      it.x = wp_x[k] + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
      it.y = wp_y[k] + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
    end else begin
      walk_x += longint'($urandom_range(0, 2 * step)) - longint'(step);
      walk_y += longint'($urandom_range(0, 2 * step)) - longint'(step);
      it.x = walk_x[23:0];
      it.y = walk_y[23:0];
    end
    return it;
  endfunction

  always @(posedge clk_i) begin
    tracker_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction result at %0t", $realtime);
      end else begin
        e = expected_q.pop_front();
        if (e.kept !== point_kept_o || e.full !== table_full_o ||
            e.count !== waypoint_count_o || e.valid !== target_valid_o ||
            e.reached !== reached_o || e.idx !== target_index_o ||
            e.tx !== target_x_mm_o || e.ty !== target_y_mm_o) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t: exp k%0d f%0d n%0d v%0d r%0d i%0d x%0h y%0h",
                     $realtime, e.kept, e.full, e.count, e.valid, e.reached, e.idx,
                     e.tx, e.ty);
            $display("  got k%0d f%0d n%0d v%0d r%0d i%0d x%0h y%0h",
                     point_kept_o, table_full_o, waypoint_count_o, target_valid_o,
                     reached_o, target_index_o, target_x_mm_o, target_y_mm_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tracker_result_t z, r;
    int unsigned phase_n;
    n_stored = 0;
    prev_x = 0;
    prev_y = 0;
    dist_acc = 0;
    first_seen = 0;
    nearest_found = 0;
    cur_idx = 0;
    min_sp = awt_pkg::MIN_SPACING_RST;
    max_sp = awt_pkg::MAX_SPACING_RST;
    curv_fs = awt_pkg::CURV_FS_RST;
    reach_r = awt_pkg::REACH_RST;
    z = '{default: '0};

    r = z;
    add_row(CMD_TRACK, 24'sd5, -24'sd5, 16'sd0, 1, r);
    r.kept = 1;
    r.count = 1;
    add_row(CMD_PATH, -24'sd8388608, 24'sd8388607, 16'sd0, 1, r);
    r = z;
    r.count = 1;
    r.valid = 1;
    r.reached = 1;
    r.tx = 24'h800000;
    r.ty = 24'h7FFFFF;
    add_row(CMD_TRACK, -24'sd8388608, 24'sd8388607, 16'sd0, 1, r);
    add_row(CMD_PATH, 24'sd8388607, -24'sd8388608, -16'sd32768, 0, z);
    add_row(CMD_PATH, 24'sd8388607, -24'sd8388608, 16'sd32767, 0, z);
    add_row(CMD_PATH, 24'sd0, 24'sd0, 16'sd0, 0, z);
    add_row(CMD_PATH, 24'sd300, 24'sd0, 16'sd1229, 0, z);
    add_row(CMD_PATH, 24'sd700, 24'sd0, -16'sd1229, 0, z);
    add_row(CMD_PATH, 24'sd1100, 24'sd0, 16'sd600, 0, z);
    add_row(CMD_PATH, 24'sd1400, 24'sd100, -16'sd1, 0, z);
    add_row(CMD_TRACK, 24'sd0, 24'sd0, 16'sd0, 0, z);
    add_row(CMD_TRACK, 24'sd8388607, 24'sd8388607, 16'sd0, 0, z);
    add_row(CMD_TRACK, -24'sd1, -24'sd1, 16'sd0, 0, z);
    add_row(CMD_PATH, -24'sd1, -24'sd1, -16'sd1, 0, z);
    add_row(CMD_TRACK, 24'sd1200, 24'sd50, 16'sd0, 0, z);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: set_all(0, 65535, 1, 65535);
        1: set_all(65535, 0, 32767, 0);
        2: set_all(100, 500, 0, 1400);
        3: set_all(300, 50, 1000, 3000);
        4: set_all(awt_pkg::MIN_SPACING_RST, awt_pkg::MAX_SPACING_RST,
                   awt_pkg::CURV_FS_RST, awt_pkg::REACH_RST);
        default: set_all($urandom_range(0, 2000), $urandom_range(0, 2000),
                         $urandom_range(1, 32767), $urandom_range(0, 65535));
      endcase
      no_gaps = (p == 3);
      phase_n = 40;
      for (int k = 0; k < phase_n; k++) begin
        if (k == phase_n / 2) drain();
        send(rand_item(30, (p == 1) ? 30000 : 400));
      end
    end

    drain();
    set_all(0, 0, 1, 5000);
    no_gaps = 0;
    while (n_stored < DEPTH) send(rand_item(0, 150));
    for (int k = 0; k < 10; k++) send(rand_item(0, 150));
    for (int k = 0; k < 40; k++) send(rand_item(100, 150));
    drain();
    set_all(65535, 65535, 32767, 65535);
    for (int k = 0; k < 20; k++) send(rand_item(40, 3000));

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/awt_pkg.sv
sv/awt_ctrl.sv
sv/awt_dp.sv
sv/adaptive_waypoint_tracker_unit.sv
dv/adaptive_waypoint_tracker_unit_tb.sv
